FILE: hdl/fpfa_pkg.sv
// ----------------------------------------------------------------------------
// fpfa_pkg
// Shared types and codes for the fixed partition fit allocator.
// ----------------------------------------------------------------------------
package fpfa_pkg;

  localparam int MAX_PARTS_DEF = 16;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_GRANTED = 2'd1;
  localparam logic [1:0] ST_NOFIT   = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic FIT_FIRST = 1'b0;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  item_id;
    logic [15:0] item_size;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  request_id;
    logic [7:0]  granted_block;
    logic [15:0] granted_size;
  } out_word_t;

  typedef struct packed {
    cmd_t        kind;
    logic [7:0]  id;
    logic [15:0] size;
  } cmd_word_t;

endpackage

FILE: hdl/fpfa_front.sv
// ----------------------------------------------------------------------------
// fpfa_front
// Accepts input words, decodes the operation and holds them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module fpfa_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  fpfa_pkg::in_word_t  in_word,
  output logic                busy,
  output logic                q_valid,
  output fpfa_pkg::cmd_word_t q_word,
  input  logic                q_pop
);
  import fpfa_pkg::*;

  cmd_word_t  q_mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       push;
  cmd_word_t  dec_word;

  always_comb begin
    dec_word.id   = in_word.item_id;
    dec_word.size = in_word.item_size;
    case (in_word.op)
      OP_ADD:   dec_word.kind = CMD_ADD;
      OP_ALLOC: dec_word.kind = CMD_ALLOC;
      OP_FREE:  dec_word.kind = CMD_FREE;
      default:  dec_word.kind = CMD_NOP;
    endcase
  end

  assign busy    = (fill_r == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (fill_r != 2'd0);
  assign q_word  = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ q_pop;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= dec_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

FILE: hdl/fpfa_back.sv
// ----------------------------------------------------------------------------
// fpfa_back
// Executes queued commands against the partition table: append, fit scan
// over the table memory one entry per cycle, and clear of the used flags.
// ----------------------------------------------------------------------------
module fpfa_back #(
  parameter int MAX_PARTS = fpfa_pkg::MAX_PARTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                q_valid,
  input  fpfa_pkg::cmd_word_t q_word,
  output logic                q_pop,
  output logic                out_valid,
  output fpfa_pkg::out_word_t out_word
);
  import fpfa_pkg::*;

  localparam int IDX_W = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int CNT_W = $clog2(MAX_PARTS + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  logic [7:0]  mem_num  [MAX_PARTS];
  logic [15:0] mem_size [MAX_PARTS];
  logic [7:0]  rd_num_r;
  logic [15:0] rd_size_r;
  logic        mem_we;
  logic [IDX_W-1:0] wr_addr;

  state_t          state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [MAX_PARTS-1:0] used_r, used_nxt;
  logic            mode_r;
  logic [IDX_W-1:0] issue_idx_r, issue_idx_nxt;
  logic            issue_more_r, issue_more_nxt;
  logic            chk_v_r, chk_v_nxt;
  logic [IDX_W-1:0] chk_idx_r, chk_idx_nxt;
  logic            found_r, found_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  logic [15:0]     best_size_r, best_size_nxt;
  logic [7:0]      best_num_r, best_num_nxt;
  logic [15:0]     want_r, want_nxt;
  logic [7:0]      id_r, id_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_word_t       out_word_r, out_word_nxt;

  logic [IDX_W-1:0] last_idx;
  logic            fit;
  logic            better;
  logic [CNT_W-1:0] cnt_dec;

  assign cnt_dec  = cnt_r - CNT_W'(1);
  assign last_idx = cnt_dec[IDX_W-1:0];
  assign wr_addr  = cnt_r[IDX_W-1:0];
  assign fit      = !used_r[chk_idx_r] && (rd_size_r >= want_r);
  assign better   = fit && (!found_r || (rd_size_r < best_size_r));

  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_num[wr_addr]  <= q_word.id;
      mem_size[wr_addr] <= q_word.size;
    end
    rd_num_r  <= mem_num[issue_idx_r];
    rd_size_r <= mem_size[issue_idx_r];
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    used_nxt       = used_r;
    issue_idx_nxt  = issue_idx_r;
    issue_more_nxt = issue_more_r;
    chk_v_nxt      = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    found_nxt      = found_r;
    best_idx_nxt   = best_idx_r;
    best_size_nxt  = best_size_r;
    best_num_nxt   = best_num_r;
    want_nxt       = want_r;
    id_nxt         = id_r;
    out_valid_nxt  = 1'b0;
    out_word_nxt   = out_word_r;
    mem_we         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          out_word_nxt.status        = ST_OK;
          out_word_nxt.request_id    = q_word.id;
          out_word_nxt.granted_block = 8'd0;
          out_word_nxt.granted_size  = 16'd0;
          case (q_word.kind)
            CMD_ADD: begin
              out_valid_nxt = 1'b1;
              if (cnt_r < CNT_W'(MAX_PARTS)) begin
                mem_we            = 1'b1;
                used_nxt[wr_addr] = 1'b0;
                cnt_nxt           = cnt_r + CNT_W'(1);
              end else begin
                out_word_nxt.status = ST_FULL;
              end
            end
            CMD_ALLOC: begin
              if (cnt_r == '0) begin
                out_valid_nxt       = 1'b1;
                out_word_nxt.status = ST_NOFIT;
              end else begin
                state_nxt      = S_SCAN;
                issue_idx_nxt  = '0;
                issue_more_nxt = 1'b1;
                found_nxt      = 1'b0;
                want_nxt       = q_word.size;
                id_nxt         = q_word.id;
              end
            end
            CMD_FREE: begin
              out_valid_nxt = 1'b1;
              used_nxt      = '0;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      S_SCAN: begin
        chk_v_nxt      = issue_more_r;
        chk_idx_nxt    = issue_idx_r;
        issue_more_nxt = issue_more_r && (issue_idx_r != last_idx);
        if (issue_more_r && (issue_idx_r != last_idx)) begin
          issue_idx_nxt = issue_idx_r + IDX_W'(1);
        end
        if (chk_v_r) begin
          if (better) begin
            found_nxt     = 1'b1;
            best_idx_nxt  = chk_idx_r;
            best_size_nxt = rd_size_r;
            best_num_nxt  = rd_num_r;
          end
          if ((fit && (mode_r == FIT_FIRST)) || (chk_idx_r == last_idx)) begin
            state_nxt      = S_DONE;
            issue_more_nxt = 1'b0;
            chk_v_nxt      = 1'b0;
          end
        end
      end

      S_DONE: begin
        state_nxt               = S_IDLE;
        out_valid_nxt           = 1'b1;
        out_word_nxt.request_id = id_r;
        if (found_r) begin
          used_nxt[best_idx_r]       = 1'b1;
          out_word_nxt.status        = ST_GRANTED;
          out_word_nxt.granted_block = best_num_r;
          out_word_nxt.granted_size  = best_size_r;
        end else begin
          out_word_nxt.status        = ST_NOFIT;
          out_word_nxt.granted_block = 8'd0;
          out_word_nxt.granted_size  = 16'd0;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    chk_idx_r   <= chk_idx_nxt;
    best_idx_r  <= best_idx_nxt;
    best_size_r <= best_size_nxt;
    best_num_r  <= best_num_nxt;
    want_r      <= want_nxt;
    id_r        <= id_nxt;
    out_word_r  <= out_word_nxt;
    issue_idx_r <= issue_idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      used_r       <= '0;
      mode_r       <= FIT_FIRST;
      issue_more_r <= 1'b0;
      chk_v_r      <= 1'b0;
      found_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      used_r       <= used_nxt;
      issue_more_r <= issue_more_nxt;
      chk_v_r      <= chk_v_nxt;
      found_r      <= found_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
    end
  end

endmodule

FILE: hdl/fixed_partition_fit_allocator.sv
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator
// Fixed partition table with first-fit or best-fit allocation.
//
//   channel  ports                    handshake
//   in       start, busy, in_word     taken when start && !busy
//   out      out_valid, out_word      one-cycle strobe, no back-pressure
//   cfg      cfg_we, cfg_wdata        written when cfg_we (fit mode)
//
// Add, free-all and reserved words pass through the command queue and the
// registered output word. An allocate scans the table memory one entry per
// cycle (registered read). busy rises only when the two-entry command queue
// is full. Synchronous active-low reset empties the table and selects first
// fit.
// ----------------------------------------------------------------------------
module fixed_partition_fit_allocator #(
  parameter int MAX_PARTS = fpfa_pkg::MAX_PARTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  fpfa_pkg::in_word_t  in_word,
  output logic                out_valid,
  output fpfa_pkg::out_word_t out_word,
  input  logic                cfg_we,
  input  logic                cfg_wdata
);
  import fpfa_pkg::*;

  logic      q_valid;
  logic      q_pop;
  cmd_word_t q_word;

  fpfa_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_word (in_word),
    .busy    (busy),
    .q_valid (q_valid),
    .q_word  (q_word),
    .q_pop   (q_pop)
  );

  fpfa_back #(
    .MAX_PARTS (MAX_PARTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_word    (q_word),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the fixed partition fit allocator. Words are sent
// on the start/busy port with random gaps, an in-order model of the
// partition table predicts each returned word, and a monitor compares every
// strobed word with the oldest prediction. Runs cover both fit modes.
// ----------------------------------------------------------------------------
module testbench;
  import fpfa_pkg::*;

  localparam int TABLE_DEPTH = MAX_PARTS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_WORDS = 325;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_word_t  in_word = '0;
  logic      out_valid;
  out_word_t out_word;
  logic      cfg_we = 1'b0;
  logic      cfg_wdata = 1'b0;

  logic [7:0]  tbl_block [TABLE_DEPTH];
  logic [15:0] tbl_size [TABLE_DEPTH];
  logic        tbl_used [TABLE_DEPTH];
  int          tbl_count = 0;
  logic        fit_sel = FIT_FIRST;

  out_word_t expected_words [$];
  int        fault_count = 0;
  int        cycle_count = 0;
  int        max_gap = 12;

  fixed_partition_fit_allocator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic out_word_t table_outcome(in_word_t w);
    out_word_t r;
    int        pick;
    r = '0;
    r.request_id = w.item_id;
    r.status = ST_OK;
    pick = -1;
    case (cmd_t'(w.op))
      CMD_ADD: begin
        if (tbl_count < TABLE_DEPTH) begin
          tbl_block[tbl_count] = w.item_id;
          tbl_size[tbl_count] = w.item_size;
          tbl_used[tbl_count] = 1'b0;
          tbl_count++;
        end else begin
          r.status = ST_FULL;
        end
      end
      CMD_ALLOC: begin
        for (int k = 0; k < tbl_count; k++) begin
          if (!tbl_used[k] && tbl_size[k] >= w.item_size) begin
            if (pick < 0 || (fit_sel != FIT_FIRST && tbl_size[k] < tbl_size[pick]))
              pick = k;
          end
        end
        if (pick >= 0) begin
          tbl_used[pick] = 1'b1;
          r.status = ST_GRANTED;
          r.granted_block = tbl_block[pick];
          r.granted_size = tbl_size[pick];
        end else begin
          r.status = ST_NOFIT;
        end
      end
      CMD_FREE: begin
        for (int k = 0; k < TABLE_DEPTH; k++) tbl_used[k] = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // result monitor: no back-pressure, every strobe must match
  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n && out_valid) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: status %0d request_id %0d", out_word.status,
               out_word.request_id);
        fault_count++;
      end else begin
        exp_w = expected_words.pop_front();
        if (out_word.status !== exp_w.status) begin
          $error("status expected %0d got %0d", exp_w.status, out_word.status);
          fault_count++;
        end
        if (out_word.request_id !== exp_w.request_id) begin
          $error("request_id expected %0d got %0d", exp_w.request_id,
                 out_word.request_id);
          fault_count++;
        end
        if (out_word.granted_block !== exp_w.granted_block) begin
          $error("granted_block expected %0d got %0d", exp_w.granted_block,
                 out_word.granted_block);
          fault_count++;
        end
        if (out_word.granted_size !== exp_w.granted_size) begin
          $error("granted_size expected %0d got %0d", exp_w.granted_size,
                 out_word.granted_size);
          fault_count++;
        end
      end
    end
  end

  // start stays high after acceptance until the next word or a pause
  task automatic issue_word(input cmd_t kind, input logic [7:0] id,
                            input logic [15:0] size);
    in_word_t w;
    int       gap;
    w.op = kind;
    w.item_id = id;
    w.item_size = size;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    expected_words.push_back(table_outcome(w));
  endtask

  task automatic wait_for_quiet();
    start <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic set_fit_mode(input logic mode);
    wait_for_quiet();
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
    fit_sel = mode;
  endtask

  task automatic test_empty_table();
    issue_word(CMD_ALLOC, 8'd7, 16'd0);
    issue_word(CMD_FREE, 8'd0, 16'd0);
    issue_word(CMD_NOP, 8'hFF, 16'hFFFF);
  endtask

  task automatic test_first_fit_and_full();
    set_fit_mode(FIT_FIRST);
    issue_word(CMD_ADD, 8'h00, 16'h0000);
    issue_word(CMD_ADD, 8'hFF, 16'hFFFF);
    issue_word(CMD_ADD, 8'h11, 16'd100);
    issue_word(CMD_ADD, 8'h22, 16'd50);
    issue_word(CMD_ADD, 8'h33, 16'd100);
    issue_word(CMD_ADD, 8'h44, 16'd50);
    issue_word(CMD_ALLOC, 8'h01, 16'd0);
    issue_word(CMD_ALLOC, 8'h02, 16'hFFFF);
    issue_word(CMD_ALLOC, 8'h03, 16'hFFFF);
    while (tbl_count < TABLE_DEPTH)
      issue_word(CMD_ADD, 8'($urandom), 16'($urandom));
    issue_word(CMD_ADD, 8'hA5, 16'h5A5A);
    issue_word(CMD_FREE, 8'hFF, 16'hFFFF);
  endtask

  task automatic test_best_fit_ties();
    set_fit_mode(1'b1);
    issue_word(CMD_ALLOC, 8'h10, 16'd40);
    issue_word(CMD_ALLOC, 8'h11, 16'd40);
    issue_word(CMD_ALLOC, 8'h12, 16'd100);
    issue_word(CMD_FREE, 8'h13, 16'd0);
  endtask

  task automatic test_random_traffic();
    int r;
    int k;
    int sz;
    for (int p = 0; p < 6; p++) begin
      set_fit_mode(logic'(p % 2));
      max_gap = (p == 2) ? 0 : (p == 4) ? 3 : 12;
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (i % 160 == 159) wait_for_quiet();
        r = $urandom_range(0, 99);
        if (r < 70) begin
          k = $urandom_range(0, TABLE_DEPTH - 1);
          case ($urandom_range(0, 3))
            0: sz = $urandom_range(0, 65535);
            1: sz = $urandom_range(0, 15);
            default: sz = int'(tbl_size[k]) + $urandom_range(0, 4) - 3;
          endcase
          if (sz < 0) sz = 0;
          if (sz > 65535) sz = 65535;
          issue_word(CMD_ALLOC, 8'($urandom), 16'(sz));
        end else if (r < 82) begin
          issue_word(CMD_FREE, 8'($urandom), 16'($urandom));
        end else if (r < 92) begin
          issue_word(CMD_ADD, 8'($urandom), 16'($urandom));
        end else begin
          issue_word(CMD_NOP, 8'($urandom), 16'($urandom));
        end
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_first_fit_and_full();
    test_best_fit_ties();
    test_random_traffic();
    wait_for_quiet();
    repeat (30) @(posedge clk);
    if (expected_words.size() != 0) begin
      $error("%0d words never returned", expected_words.size());
      fault_count++;
    end
    if (fault_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/fpfa_pkg.sv
hdl/fpfa_front.sv
hdl/fpfa_back.sv
hdl/fixed_partition_fit_allocator.sv
sim/testbench.sv
